[rtl/mhtm_pkg.sv]
package mhtm_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int ID_BITS_DEF = 10;

	localparam int ACTION_W = 3;
	localparam int TIMER_ID_W = 10;
	localparam int TIMEOUT_W = 31;
	localparam int TIME_W = 32;
	localparam int KIND_W = 3;

	localparam logic [ACTION_W-1:0] ACT_ADD = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_UPDATE = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_CLOSE = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_TICK = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_POP = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd5;

	localparam logic [KIND_W-1:0] KIND_DONE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CLOSED = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SUMMARY = 3'd3;
	localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd4;
	localparam logic [KIND_W-1:0] KIND_FULL = 3'd5;

	// wrapping time order: a before b when the signed difference is negative
	function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return d[TIME_W-1];
	endfunction

endpackage

[rtl/mhtm_in_if.sv]
interface mhtm_in_if;
	logic valid;
	logic ready;
	logic [mhtm_pkg::ACTION_W-1:0] action;
	logic [mhtm_pkg::TIMER_ID_W-1:0] timer_id;
	logic [mhtm_pkg::TIMEOUT_W-1:0] timeout_ms;
	logic [mhtm_pkg::TIME_W-1:0] now_ms;

	modport source(output valid, action, timer_id, timeout_ms, now_ms, input ready);
	modport sink(input valid, action, timer_id, timeout_ms, now_ms, output ready);
endinterface

[rtl/mhtm_out_if.sv]
interface mhtm_out_if;
	logic valid;
	logic ready;
	logic [mhtm_pkg::KIND_W-1:0] kind;
	logic [mhtm_pkg::TIMER_ID_W-1:0] event_id;
	logic signed [mhtm_pkg::TIME_W-1:0] next_wait_ms;
	logic last;

	modport source(output valid, kind, event_id, next_wait_ms, last, input ready);
	modport sink(input valid, kind, event_id, next_wait_ms, last, output ready);
endinterface

[rtl/min_heap_timer_manager.sv]
// sift: per level down the states DN, DNL, DNR and DNC (DNR skipped at a node with only a
// left child), per level up the states UP and UPC
// tick: a root check passes TK, TKRD and EMIT, plus a removal per expired timer; output stalls
// hold EMIT; one item at a time; the single read port of the heap memory sets the pace
// reset clears the fill count and control only; no clearing pass, the position
// table is trusted only when the heap slot it names holds the same id
module min_heap_timer_manager #(
	parameter int CAPACITY = mhtm_pkg::CAPACITY_DEF,
	parameter int ID_BITS = mhtm_pkg::ID_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	mhtm_in_if.sink cmd,
	mhtm_out_if.source evt
);

	localparam int SLOT_BITS = $clog2(CAPACITY);
	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam int J_BITS = SLOT_BITS + 2;
	localparam int TW = mhtm_pkg::TIME_W;
	localparam int ENTRY_W = ID_BITS + TW;
	localparam int ID_COUNT = 1 << ID_BITS;
	localparam logic [CNT_BITS-1:0] CAP_N = CNT_BITS'(CAPACITY);

	typedef enum logic [3:0] {
		ST_IDLE, ST_POS, ST_CHK, ST_RM, ST_RMX, ST_DN, ST_DNL, ST_DNR,
		ST_DNC, ST_UP, ST_UPC, ST_FIN, ST_TK, ST_TKRD, ST_EMIT
	} state_t;

	state_t state_q, ret_q;

	logic [mhtm_pkg::ACTION_W-1:0] act_q;
	logic [ID_BITS-1:0] id_q;
	logic [TW-1:0] exp_q, now_q;
	logic [CNT_BITS-1:0] cnt_q, n_q;
	logic [SLOT_BITS-1:0] i_q, start_q, p_q, cidx_q;
	logic [ID_BITS-1:0] x_id_q, c_id_q;
	logic [TW-1:0] x_exp_q, c_exp_q;

	// pending result word
	logic [mhtm_pkg::KIND_W-1:0] res_kind_q;
	logic [mhtm_pkg::TIMER_ID_W-1:0] res_id_q;
	logic [TW-1:0] res_wait_q;
	logic res_last_q;

	// output register
	logic evt_valid_q;
	logic [mhtm_pkg::KIND_W-1:0] evt_kind_q;
	logic [mhtm_pkg::TIMER_ID_W-1:0] evt_id_q;
	logic [TW-1:0] evt_wait_q;
	logic evt_last_q;

	// heap memory: {id, expiry} per slot
	logic h_we;
	logic [SLOT_BITS-1:0] h_waddr, h_raddr;
	logic [ENTRY_W-1:0] h_wdata, h_rdata;

	// id to slot table
	logic p_we;
	logic [ID_BITS-1:0] p_waddr, p_raddr;
	logic [SLOT_BITS-1:0] p_wdata, p_rdata;

	mhtm_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	mhtm_ram #(.WIDTH(SLOT_BITS), .DEPTH(ID_COUNT)) u_pos (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	logic [ID_BITS-1:0] hrd_id;
	logic [TW-1:0] hrd_exp, tick_d;
	logic [J_BITS-1:0] j_w, jr_w, n_ext;
	logic [SLOT_BITS-1:0] parent_w;
	logic present;

	assign hrd_id = h_rdata[ENTRY_W-1:TW];
	assign hrd_exp = h_rdata[TW-1:0];
	assign tick_d = hrd_exp - now_q;
	// left child 2i+1 and right child 2i+2
	assign j_w = J_BITS'({i_q, 1'b1});
	assign jr_w = j_w + J_BITS'(1);
	assign n_ext = J_BITS'(n_q);
	assign parent_w = SLOT_BITS'((i_q - SLOT_BITS'(1)) >> 1);
	// table entry counts only if it points at a live slot holding this id
	assign present = (CNT_BITS'(p_q) < cnt_q) && (hrd_id == id_q);

	assign cmd.ready = (state_q == ST_IDLE);

	assign evt.valid = evt_valid_q;
	assign evt.kind = evt_kind_q;
	assign evt.event_id = evt_id_q;
	assign evt.next_wait_ms = evt_wait_q;
	assign evt.last = evt_last_q;

	// memory ports follow the sequencer state
	always_comb begin
		h_we = 1'b0;
		h_waddr = i_q;
		h_wdata = {x_id_q, x_exp_q};
		h_raddr = '0;
		p_we = 1'b0;
		p_waddr = x_id_q;
		p_wdata = i_q;
		p_raddr = ID_BITS'(cmd.timer_id);
		case (state_q)
			ST_POS: h_raddr = p_rdata;
			ST_RM: h_raddr = SLOT_BITS'(cnt_q - CNT_BITS'(1));
			ST_DN: h_raddr = SLOT_BITS'(j_w);
			ST_DNL: h_raddr = SLOT_BITS'(jr_w);
			ST_DNC: begin
				// child moves up into the hole
				if (!mhtm_pkg::earlier(x_exp_q, c_exp_q)) begin
					h_we = 1'b1;
					h_wdata = {c_id_q, c_exp_q};
					p_we = 1'b1;
					p_waddr = c_id_q;
				end
			end
			ST_UP: h_raddr = parent_w;
			ST_UPC: begin
				// parent moves down into the hole
				if (!mhtm_pkg::earlier(hrd_exp, x_exp_q)) begin
					h_we = 1'b1;
					h_wdata = h_rdata;
					p_we = 1'b1;
					p_waddr = hrd_id;
				end
			end
			ST_FIN: begin
				h_we = 1'b1;
				p_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			cnt_q <= '0;
			evt_valid_q <= 1'b0;
		end else begin
			// the emit state always leaves the output register full
			if (evt.ready && state_q != ST_EMIT) begin
				evt_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						act_q <= cmd.action;
						id_q <= ID_BITS'(cmd.timer_id);
						exp_q <= cmd.now_ms + TW'(cmd.timeout_ms);
						now_q <= cmd.now_ms;
						res_id_q <= '0;
						res_wait_q <= '0;
						res_last_q <= 1'b1;
						ret_q <= ST_IDLE;
						case (cmd.action)
							mhtm_pkg::ACT_ADD, mhtm_pkg::ACT_UPDATE,
							mhtm_pkg::ACT_CLOSE: begin
								res_kind_q <= mhtm_pkg::KIND_DONE;
								state_q <= ST_POS;
							end
							mhtm_pkg::ACT_TICK: begin
								res_kind_q <= mhtm_pkg::KIND_DONE;
								state_q <= ST_TK;
							end
							mhtm_pkg::ACT_POP: begin
								p_q <= '0;
								if (cnt_q == '0) begin
									res_kind_q <= mhtm_pkg::KIND_IGNORED;
									state_q <= ST_EMIT;
								end else begin
									res_kind_q <= mhtm_pkg::KIND_DONE;
									state_q <= ST_RM;
								end
							end
							mhtm_pkg::ACT_CLEAR: begin
								res_kind_q <= mhtm_pkg::KIND_DONE;
								cnt_q <= '0;
								state_q <= ST_EMIT;
							end
							default: begin
								res_kind_q <= mhtm_pkg::KIND_IGNORED;
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_POS: begin
					p_q <= p_rdata;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					x_id_q <= id_q;
					x_exp_q <= exp_q;
					if (act_q == mhtm_pkg::ACT_CLOSE) begin
						if (present) begin
							res_kind_q <= mhtm_pkg::KIND_CLOSED;
							res_id_q <= mhtm_pkg::TIMER_ID_W'(id_q);
							state_q <= ST_RM;
						end else begin
							res_kind_q <= mhtm_pkg::KIND_IGNORED;
							state_q <= ST_EMIT;
						end
					end else if (present) begin
						// re-arm in place, then sift
						i_q <= p_q;
						start_q <= p_q;
						n_q <= cnt_q;
						state_q <= ST_DN;
					end else if (act_q == mhtm_pkg::ACT_UPDATE) begin
						res_kind_q <= mhtm_pkg::KIND_IGNORED;
						state_q <= ST_EMIT;
					end else if (cnt_q == CAP_N) begin
						res_kind_q <= mhtm_pkg::KIND_FULL;
						state_q <= ST_EMIT;
					end else begin
						// new timer at the tail; down pass ends at once, then up
						i_q <= SLOT_BITS'(cnt_q);
						start_q <= SLOT_BITS'(cnt_q);
						cnt_q <= cnt_q + CNT_BITS'(1);
						n_q <= cnt_q + CNT_BITS'(1);
						state_q <= ST_DN;
					end
				end
				ST_RM: begin
					// last slot fills the removed one
					cnt_q <= cnt_q - CNT_BITS'(1);
					n_q <= cnt_q - CNT_BITS'(1);
					if (CNT_BITS'(p_q) < cnt_q - CNT_BITS'(1)) begin
						state_q <= ST_RMX;
					end else if (act_q == mhtm_pkg::ACT_TICK) begin
						state_q <= ST_TK;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_RMX: begin
					x_id_q <= hrd_id;
					x_exp_q <= hrd_exp;
					i_q <= p_q;
					start_q <= p_q;
					state_q <= ST_DN;
				end
				ST_DN: begin
					cidx_q <= SLOT_BITS'(j_w);
					if (j_w >= n_ext) begin
						state_q <= (i_q != start_q) ? ST_FIN : ST_UP;
					end else begin
						state_q <= ST_DNL;
					end
				end
				ST_DNL: begin
					c_id_q <= hrd_id;
					c_exp_q <= hrd_exp;
					state_q <= (jr_w < n_ext) ? ST_DNR : ST_DNC;
				end
				ST_DNR: begin
					// right child wins only when strictly earlier
					if (mhtm_pkg::earlier(hrd_exp, c_exp_q)) begin
						c_id_q <= hrd_id;
						c_exp_q <= hrd_exp;
						cidx_q <= cidx_q + SLOT_BITS'(1);
					end
					state_q <= ST_DNC;
				end
				ST_DNC: begin
					if (mhtm_pkg::earlier(x_exp_q, c_exp_q)) begin
						state_q <= (i_q != start_q) ? ST_FIN : ST_UP;
					end else begin
						i_q <= cidx_q;
						state_q <= ST_DN;
					end
				end
				ST_UP: begin
					p_q <= parent_w;
					state_q <= (i_q == '0) ? ST_FIN : ST_UPC;
				end
				ST_UPC: begin
					if (mhtm_pkg::earlier(hrd_exp, x_exp_q)) begin
						state_q <= ST_FIN;
					end else begin
						i_q <= p_q;
						state_q <= ST_UP;
					end
				end
				ST_FIN: begin
					state_q <= (act_q == mhtm_pkg::ACT_TICK) ? ST_TK : ST_EMIT;
				end
				ST_TK: begin
					if (cnt_q == '0) begin
						res_kind_q <= mhtm_pkg::KIND_SUMMARY;
						res_id_q <= '0;
						res_wait_q <= '1;
						res_last_q <= 1'b1;
						ret_q <= ST_IDLE;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_TKRD;
					end
				end
				ST_TKRD: begin
					if ((tick_d == '0) || tick_d[TW-1]) begin
						// root expired: report it, then remove slot zero
						res_kind_q <= mhtm_pkg::KIND_EXPIRED;
						res_id_q <= mhtm_pkg::TIMER_ID_W'(hrd_id);
						res_wait_q <= '0;
						res_last_q <= 1'b0;
						p_q <= '0;
						ret_q <= ST_RM;
					end else begin
						res_kind_q <= mhtm_pkg::KIND_SUMMARY;
						res_id_q <= '0;
						res_wait_q <= tick_d;
						res_last_q <= 1'b1;
						ret_q <= ST_IDLE;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!evt_valid_q || evt.ready) begin
						evt_valid_q <= 1'b1;
						evt_kind_q <= res_kind_q;
						evt_id_q <= res_id_q;
						evt_wait_q <= res_wait_q;
						evt_last_q <= res_last_q;
						state_q <= ret_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/mhtm_ram.sv]
module mhtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[tb/mhtm_checker.sv]
module mhtm_checker (
	input logic clk,
	input logic arst_n,
	mhtm_in_if.sink cmd,
	mhtm_out_if.sink evt,
	output int fail_count,
	output int pending
);

	localparam int CAP = mhtm_pkg::CAPACITY_DEF;
	localparam int IDS = 1 << mhtm_pkg::ID_BITS_DEF;

	typedef struct packed {
		logic [mhtm_pkg::KIND_W-1:0] kind;
		logic [mhtm_pkg::TIMER_ID_W-1:0] event_id;
		logic [mhtm_pkg::TIME_W-1:0] next_wait_ms;
		logic last;
	} event_word_t;

	logic [mhtm_pkg::TIMER_ID_W-1:0] tq_id[CAP];
	logic [mhtm_pkg::TIME_W-1:0] tq_exp[CAP];
	int tq_count;
	int slot_of[IDS];
	bit armed[IDS];
	event_word_t expected_events[$];

	function automatic bit before_slot(int a, int b);
		logic [mhtm_pkg::TIME_W-1:0] d;
		d = tq_exp[a] - tq_exp[b];
		return d[mhtm_pkg::TIME_W-1];
	endfunction

	function automatic void swap_slots(int a, int b);
		logic [mhtm_pkg::TIMER_ID_W-1:0] ti;
		logic [mhtm_pkg::TIME_W-1:0] te;
		ti = tq_id[a]; tq_id[a] = tq_id[b]; tq_id[b] = ti;
		te = tq_exp[a]; tq_exp[a] = tq_exp[b]; tq_exp[b] = te;
		slot_of[tq_id[a]] = a;
		slot_of[tq_id[b]] = b;
	endfunction

	function automatic void rise(int i);
		int p;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (before_slot(p, i)) break;
			swap_slots(p, i);
			i = p;
		end
	endfunction

	function automatic bit sink_down(int start, int n);
		int i;
		int j;
		i = start;
		j = 2 * i + 1;
		while (j < n) begin
			if (j + 1 < n && before_slot(j + 1, j)) j++;
			if (before_slot(i, j)) break;
			swap_slots(i, j);
			i = j;
			j = 2 * i + 1;
		end
		return i > start;
	endfunction

	function automatic void resettle(int i);
		if (!sink_down(i, tq_count)) rise(i);
	endfunction

	function automatic void drop_slot(int i);
		int n;
		n = tq_count - 1;
		if (i < n) begin
			swap_slots(i, n);
			if (!sink_down(i, n)) rise(i);
		end
		armed[tq_id[n]] = 0;
		slot_of[tq_id[n]] = 0;
		tq_count = n;
	endfunction

	function automatic void post(logic [mhtm_pkg::KIND_W-1:0] k,
			logic [mhtm_pkg::TIMER_ID_W-1:0] id, logic [mhtm_pkg::TIME_W-1:0] w);
		event_word_t e;
		e.kind = k; e.event_id = id; e.next_wait_ms = w; e.last = 0;
		expected_events.insert(expected_events.size(), e);
	endfunction

	function automatic void predict_timer_events(logic [mhtm_pkg::ACTION_W-1:0] act,
			logic [mhtm_pkg::TIMER_ID_W-1:0] id, logic [mhtm_pkg::TIMEOUT_W-1:0] tmo,
			logic [mhtm_pkg::TIME_W-1:0] now);
		logic [mhtm_pkg::TIME_W-1:0] expiry;
		logic [mhtm_pkg::TIME_W-1:0] d;
		expiry = now + {1'b0, tmo};
		case (act)
			mhtm_pkg::ACT_ADD: begin
				if (armed[id]) begin
					tq_exp[slot_of[id]] = expiry;
					resettle(slot_of[id]);
					post(mhtm_pkg::KIND_DONE, '0, '0);
				end else if (tq_count >= CAP) begin
					post(mhtm_pkg::KIND_FULL, '0, '0);
				end else begin
					tq_id[tq_count] = id;
					tq_exp[tq_count] = expiry;
					slot_of[id] = tq_count;
					armed[id] = 1;
					tq_count++;
					rise(tq_count - 1);
					post(mhtm_pkg::KIND_DONE, '0, '0);
				end
			end
			mhtm_pkg::ACT_UPDATE: begin
				if (armed[id]) begin
					tq_exp[slot_of[id]] = expiry;
					resettle(slot_of[id]);
					post(mhtm_pkg::KIND_DONE, '0, '0);
				end else post(mhtm_pkg::KIND_IGNORED, '0, '0);
			end
			mhtm_pkg::ACT_CLOSE: begin
				if (armed[id] && tq_count > 0) begin
					drop_slot(slot_of[id]);
					post(mhtm_pkg::KIND_CLOSED, id, '0);
				end else post(mhtm_pkg::KIND_IGNORED, '0, '0);
			end
			mhtm_pkg::ACT_TICK: begin
				while (tq_count > 0) begin
					d = tq_exp[0] - now;
					if (d != 0 && !d[mhtm_pkg::TIME_W-1]) break;
					post(mhtm_pkg::KIND_EXPIRED, tq_id[0], '0);
					drop_slot(0);
				end
				if (tq_count > 0) post(mhtm_pkg::KIND_SUMMARY, '0, tq_exp[0] - now);
				else post(mhtm_pkg::KIND_SUMMARY, '0, '1);
			end
			mhtm_pkg::ACT_POP: begin
				if (tq_count > 0) begin
					drop_slot(0);
					post(mhtm_pkg::KIND_DONE, '0, '0);
				end else post(mhtm_pkg::KIND_IGNORED, '0, '0);
			end
			mhtm_pkg::ACT_CLEAR: begin
				tq_count = 0;
				foreach (armed[i]) begin
					armed[i] = 0;
					slot_of[i] = 0;
				end
				post(mhtm_pkg::KIND_DONE, '0, '0);
			end
			default: post(mhtm_pkg::KIND_IGNORED, '0, '0);
		endcase
		expected_events[expected_events.size() - 1].last = 1'b1;
	endfunction

	assign pending = expected_events.size();

	always @(posedge clk) begin
		event_word_t got;
		event_word_t want;
		if (!arst_n) begin
			fail_count = 0;
			tq_count = 0;
			foreach (armed[i]) begin
				armed[i] = 0;
				slot_of[i] = 0;
			end
			expected_events.delete();
		end else begin
			// outputs first: a word predicted this edge cannot leave the same edge
			if (evt.valid && evt.ready) begin
				got.kind = evt.kind;
				got.event_id = evt.event_id;
				got.next_wait_ms = evt.next_wait_ms;
				got.last = evt.last;
				if (expected_events.size() == 0) begin
					$display("%0t: unexpected word kind=%0d id=%0d wait=%0d last=%0b",
						$time, got.kind, got.event_id, $signed(got.next_wait_ms), got.last);
					fail_count++;
				end else begin
					want = expected_events.pop_front();
					if (got !== want) begin
						$display("%0t: expected kind=%0d id=%0d wait=%0d last=%0b",
							$time, want.kind, want.event_id, $signed(want.next_wait_ms),
							want.last);
						$display("%0t: actual   kind=%0d id=%0d wait=%0d last=%0b",
							$time, got.kind, got.event_id, $signed(got.next_wait_ms), got.last);
						fail_count++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				predict_timer_events(cmd.action, cmd.timer_id, cmd.timeout_ms, cmd.now_ms);
		end
	end
endmodule

[tb/tb_min_heap_timer_manager.sv]
module tb_min_heap_timer_manager;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending;
	int cycle_count = 0;
	// idle odds in percent, changed per phase
	int send_idle_pct;
	int recv_idle_pct;
	// the current clock of the stimulus, advanced a little per word
	logic [mhtm_pkg::TIME_W-1:0] clock_ms;
	// small id pool so that adds, closes and updates hit live timers
	logic [mhtm_pkg::TIMER_ID_W-1:0] id_pool[8];

	mhtm_in_if cmd();
	mhtm_out_if evt();

	min_heap_timer_manager dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.evt(evt.source)
	);

	mhtm_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd.sink),
		.evt(evt.sink),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// cycle limit: worst tick of 33 words at a long receiver stall, times many
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 900000) begin
			$display("min_heap_timer_manager test failed");
			$finish;
		end
	end

	// receiver: random stall per cycle, one assignment per edge
	always @(posedge clk) begin
		evt.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// one word offered with valid held until it is taken; gaps only between words
	task automatic send_word(logic [mhtm_pkg::ACTION_W-1:0] act,
			logic [mhtm_pkg::TIMER_ID_W-1:0] id, logic [mhtm_pkg::TIMEOUT_W-1:0] tmo,
			logic [mhtm_pkg::TIME_W-1:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 0;
			@(posedge clk);
		end
		cmd.valid <= 1;
		cmd.action <= act;
		cmd.timer_id <= id;
		cmd.timeout_ms <= tmo;
		cmd.now_ms <= now;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
	endtask

	// mostly short timeouts around now so that ticks see real expiries
	function automatic logic [mhtm_pkg::TIMEOUT_W-1:0] pick_timeout();
		case ($urandom_range(9))
			0: return '1;
			1: return '0;
			2: return mhtm_pkg::TIMEOUT_W'($urandom);
			default: return mhtm_pkg::TIMEOUT_W'($urandom_range(200));
		endcase
	endfunction

	task automatic random_words(int n);
		logic [mhtm_pkg::ACTION_W-1:0] act;
		logic [mhtm_pkg::TIMER_ID_W-1:0] id;
		int r;
		repeat (n) begin
			r = int'($urandom_range(99));
			if (r < 35) act = mhtm_pkg::ACT_ADD;
			else if (r < 47) act = mhtm_pkg::ACT_UPDATE;
			else if (r < 59) act = mhtm_pkg::ACT_CLOSE;
			else if (r < 82) act = mhtm_pkg::ACT_TICK;
			else if (r < 90) act = mhtm_pkg::ACT_POP;
			else if (r < 94) act = mhtm_pkg::ACT_CLEAR;
			else act = mhtm_pkg::ACTION_W'($urandom_range(7));
			id = ($urandom_range(3) == 0) ? mhtm_pkg::TIMER_ID_W'($urandom)
				: id_pool[$urandom_range(7)];
			clock_ms = clock_ms + $urandom_range(60);
			if ($urandom_range(19) == 0) clock_ms = $urandom;
			send_word(act, id, pick_timeout(), clock_ms);
		end
	endtask

	task automatic drain();
		cmd.valid <= 0;
		while (pending != 0) @(posedge clk);
		// the block may still be writing back after its last word
		repeat (40) @(posedge clk);
	endtask

	initial begin
		arst_n = 0;
		cmd.valid = 0;
		cmd.action = '0;
		cmd.timer_id = '0;
		cmd.timeout_ms = '0;
		cmd.now_ms = '0;
		send_idle_pct = 29;
		recv_idle_pct = 67;
		clock_ms = 32'hFFFF_FF00;
		foreach (id_pool[i]) id_pool[i] = mhtm_pkg::TIMER_ID_W'($urandom);
		id_pool[0] = '0;
		id_pool[1] = '1;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty cases, extremes of each field, unused actions
		send_word(mhtm_pkg::ACT_POP, '0, '0, '0);
		send_word(mhtm_pkg::ACT_TICK, '0, '0, '0);
		send_word(mhtm_pkg::ACT_UPDATE, 10'd5, '1, '1);
		send_word(mhtm_pkg::ACT_CLOSE, '1, '0, '0);
		send_word(3'd6, '1, '1, '1);
		send_word(3'd7, '0, '0, '0);
		// adds straddling the time wrap, one re-armed, equal expiries
		send_word(mhtm_pkg::ACT_ADD, '1, 31'd100, 32'hFFFF_FFF0);
		send_word(mhtm_pkg::ACT_ADD, '0, 31'd5, 32'hFFFF_FFF0);
		send_word(mhtm_pkg::ACT_ADD, 10'd7, '1, 32'h0);
		send_word(mhtm_pkg::ACT_ADD, 10'd9, 31'd5, 32'hFFFF_FFF0);
		send_word(mhtm_pkg::ACT_ADD, '1, 31'd1, 32'hFFFF_FFF0);
		send_word(mhtm_pkg::ACT_UPDATE, 10'd7, '0, 32'hFFFF_FFF0);
		send_word(mhtm_pkg::ACT_UPDATE, '0, 31'd300, 32'hFFFF_FFF0);
		send_word(mhtm_pkg::ACT_TICK, '0, '0, 32'hFFFF_FFF5);
		send_word(mhtm_pkg::ACT_CLOSE, '0, '0, 32'h0);
		send_word(mhtm_pkg::ACT_TICK, '0, '0, 32'h0);
		// fill to capacity then one more new id to hit full
		for (int i = 0; i < mhtm_pkg::CAPACITY_DEF + 1; i++)
			send_word(mhtm_pkg::ACT_ADD, 10'(100 + i), 31'($urandom_range(50)), 32'd1000);
		send_word(mhtm_pkg::ACT_ADD, 10'd900, '0, 32'd1000);
		send_word(mhtm_pkg::ACT_POP, '0, '0, 32'd1000);
		send_word(mhtm_pkg::ACT_TICK, '0, '0, 32'd1030);
		send_word(mhtm_pkg::ACT_CLEAR, '0, '0, '0);
		send_word(mhtm_pkg::ACT_TICK, '0, '0, '0);
		drain();

		random_words(40);
		drain();
		send_idle_pct = 67;
		recv_idle_pct = 29;
		random_words(40);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_words(40);
		drain();

		if (fail_count == 0) begin
			$display("min_heap_timer_manager test passed");
		end else begin
			$display("min_heap_timer_manager test failed");
		end
		$finish;
	end
endmodule
